// ===== src/bfiq_pkg.sv =====
package bfiq_pkg;

  localparam int unsigned MAX_FILTER_BITS_DEF = 2097152;
  localparam int unsigned MAX_HASHES_DEF      = 32;

  localparam int unsigned NH_W  = 6;
  localparam int unsigned FB_W  = 22;
  localparam int unsigned KEY_W = 32;

  localparam logic [NH_W-1:0] HASH_CNT_RST    = 6'd7;
  localparam logic [FB_W-1:0] FILTER_BITS_RST = 22'd1168830;

  // Register indexes on the configuration port.
  localparam logic REG_HASH_CNT    = 1'b0;
  localparam logic REG_FILTER_BITS = 1'b1;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
  localparam logic [63:0] FMIX1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX2 = 64'hc4ceb9fe1a85ec53;

  // Phases of the hash sequence, one 64-bit multiplication each.
  localparam logic [2:0] PH_K1_C1 = 3'd0;
  localparam logic [2:0] PH_K1_C2 = 3'd1;
  localparam logic [2:0] PH_H1_F1 = 3'd2;
  localparam logic [2:0] PH_H1_F2 = 3'd3;
  localparam logic [2:0] PH_H2_F1 = 3'd4;
  localparam logic [2:0] PH_H2_F2 = 3'd5;

  typedef struct packed {
    logic full;
    logic empty;
  } bfiq_qstat_t;

  function automatic logic [63:0] mul_const(input logic [2:0] ph);
    logic [63:0] c;
    begin
      case (ph)
        PH_K1_C1: c = MM_C1;
        PH_K1_C2: c = MM_C2;
        PH_H1_F1: c = FMIX1;
        PH_H1_F2: c = FMIX2;
        PH_H2_F1: c = FMIX1;
        PH_H2_F2: c = FMIX2;
        default:  c = 64'd0;
      endcase
      return c;
    end
  endfunction

endpackage

// ===== src/bfiq_front.sv =====
module bfiq_front #(
  parameter int unsigned MAX_FILTER_BITS = bfiq_pkg::MAX_FILTER_BITS_DEF,
  parameter int unsigned MAX_HASHES      = bfiq_pkg::MAX_HASHES_DEF,
  parameter int unsigned EW              = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         mode,
  input  logic [bfiq_pkg::KEY_W-1:0]   key,
  input  logic [bfiq_pkg::NH_W-1:0]    hash_count,
  input  logic [bfiq_pkg::FB_W-1:0]    filter_bits,
  output logic                         busy,
  input  bfiq_pkg::bfiq_qstat_t        qstat,
  output logic                         push,
  output logic [EW-1:0]                push_data
);
  import bfiq_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FILTER_BITS);
  localparam int unsigned KW = $clog2(MAX_HASHES + 1);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_DIV  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t       state_r, state_nxt;
  logic [2:0]    ph_r, ph_nxt;
  logic [1:0]    pp_r, pp_nxt;
  logic [4:0]    dv_r, dv_nxt;
  logic [63:0]   opa_r, opa_nxt, acc_r, acc_nxt;
  logic [63:0]   h1_r, h1_nxt, h2_r, h2_nxt;
  logic [63:0]   da_r, da_nxt, db_r, db_nxt;
  logic [AW-1:0] ra_r, ra_nxt, rb_r, rb_nxt, rc_r, rc_nxt;
  logic          mode_r, mode_nxt;
  logic [AW:0]   m_r, m_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;

  logic [63:0]   kc;
  logic [31:0]   ma, mb;
  logic [63:0]   prod, fin, k1x, h1p, h2p, h2f, h1n;
  logic [31:0]   fb32, nh32;
  logic [AW:0]   cinc, cfin;

  function automatic logic [AW-1:0] dstep(input logic [AW-1:0] r, input logic b,
                                          input logic [AW:0] m);
    logic [AW:0] t;
    begin
      t = {r, b};
      if (t >= m) t = t - m;
      return t[AW-1:0];
    end
  endfunction

  assign busy = (state_r != F_IDLE);
  assign kc   = mul_const(ph_r);

  always_comb begin
    case (pp_r)
      2'd0:    begin ma = opa_r[31:0];  mb = kc[31:0];  end
      2'd1:    begin ma = opa_r[31:0];  mb = kc[63:32]; end
      default: begin ma = opa_r[63:32]; mb = kc[31:0];  end
    endcase
  end
  assign prod = ma * mb;
  assign fin  = acc_r + {prod[31:0], 32'd0};

  assign fb32 = 32'(filter_bits);
  assign nh32 = 32'(hash_count);

  // The remainder of 2^64 is that of 2^64-1, plus one, wrapped.
  assign cinc = {1'b0, rc_r} + {{AW{1'b0}}, 1'b1};
  assign cfin = (cinc == m_r) ? '0 : cinc;

  assign push      = (state_r == F_PUSH) && !qstat.full;
  assign push_data = {mode_r, m_r, cnt_r, ra_r, rb_r, cfin[AW-1:0], h1_r, h2_r};

  always_comb begin
    state_nxt = state_r;
    ph_nxt = ph_r; pp_nxt = pp_r; dv_nxt = dv_r;
    opa_nxt = opa_r; acc_nxt = acc_r; h1_nxt = h1_r; h2_nxt = h2_r;
    da_nxt = da_r; db_nxt = db_r;
    ra_nxt = ra_r; rb_nxt = rb_r; rc_nxt = rc_r;
    mode_nxt = mode_r; m_nxt = m_r; cnt_nxt = cnt_r;
    k1x = fin ^ 64'd4;
    h1p = k1x + 64'd4;
    h2p = 64'd4 + h1p;
    h2f = fin ^ (fin >> 33);
    h1n = h1_r + h2f;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          mode_nxt = mode;
          opa_nxt  = {32'd0, key};
          ph_nxt   = PH_K1_C1;
          pp_nxt   = 2'd0;
          if (fb32 == 32'd0) m_nxt = (AW+1)'(1);
          else if (fb32 > 32'(MAX_FILTER_BITS)) m_nxt = (AW+1)'(MAX_FILTER_BITS);
          else m_nxt = (AW+1)'(fb32);
          if (nh32 > 32'(MAX_HASHES)) cnt_nxt = KW'(MAX_HASHES);
          else cnt_nxt = KW'(nh32);
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        case (pp_r)
          2'd0: begin acc_nxt = prod; pp_nxt = 2'd1; end
          2'd1: begin acc_nxt = fin;  pp_nxt = 2'd2; end
          default: begin
            pp_nxt = 2'd0;
            ph_nxt = ph_r + 3'd1;
            case (ph_r)
              PH_K1_C1: opa_nxt = {fin[32:0], fin[63:33]};
              PH_K1_C2: begin
                opa_nxt = h1p ^ (h1p >> 33);
                h2_nxt  = h2p;
              end
              PH_H1_F1: opa_nxt = fin ^ (fin >> 33);
              PH_H1_F2: begin
                h1_nxt  = fin ^ (fin >> 33);
                opa_nxt = h2_r ^ (h2_r >> 33);
              end
              PH_H2_F1: opa_nxt = fin ^ (fin >> 33);
              default: begin
                h1_nxt = h1n;
                h2_nxt = h2f + h1n;
                da_nxt = h1n;
                db_nxt = h2f + h1n;
                ra_nxt = '0; rb_nxt = '0; rc_nxt = '0;
                dv_nxt = '0;
                state_nxt = F_DIV;
              end
            endcase
          end
        endcase
      end
      F_DIV: begin
        // Two quotient bits a cycle for h1, h2 and 2^64-1 side by side.
        ra_nxt = dstep(dstep(ra_r, da_r[63], m_r), da_r[62], m_r);
        rb_nxt = dstep(dstep(rb_r, db_r[63], m_r), db_r[62], m_r);
        rc_nxt = dstep(dstep(rc_r, 1'b1, m_r), 1'b1, m_r);
        da_nxt = {da_r[61:0], 2'b00};
        db_nxt = {db_r[61:0], 2'b00};
        dv_nxt = dv_r + 5'd1;
        if (dv_r == 5'd31) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!qstat.full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph_r <= ph_nxt; pp_r <= pp_nxt; dv_r <= dv_nxt;
    opa_r <= opa_nxt; acc_r <= acc_nxt; h1_r <= h1_nxt; h2_r <= h2_nxt;
    da_r <= da_nxt; db_r <= db_nxt;
    ra_r <= ra_nxt; rb_r <= rb_nxt; rc_r <= rc_nxt;
    mode_r <= mode_nxt; m_r <= m_nxt; cnt_r <= cnt_nxt;
  end

endmodule

// ===== src/bfiq_queue.sv =====
module bfiq_queue #(
  parameter int unsigned EW = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [EW-1:0]         push_data,
  input  logic                  pop,
  output logic [EW-1:0]         pop_data,
  output bfiq_pkg::bfiq_qstat_t qstat
);
  import bfiq_pkg::*;

  logic [EW-1:0] ent_r [2];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign qstat.full  = (cnt_r == 2'd2);
  assign qstat.empty = (cnt_r == 2'd0);
  assign pop_data    = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_data;
  end

endmodule

// ===== src/bfiq_back.sv =====
module bfiq_back #(
  parameter int unsigned MAX_FILTER_BITS = bfiq_pkg::MAX_FILTER_BITS_DEF,
  parameter int unsigned MAX_HASHES      = bfiq_pkg::MAX_HASHES_DEF,
  parameter int unsigned EW              = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bfiq_pkg::bfiq_qstat_t qstat,
  input  logic [EW-1:0]         pop_data,
  output logic                  pop,
  output logic                  clearing,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_maybe_present
);
  import bfiq_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FILTER_BITS);
  localparam int unsigned KW = $clog2(MAX_HASHES + 1);

  typedef enum logic [4:0] {
    B_CLR  = 5'b00001,
    B_IDLE = 5'b00010,
    B_ACC  = 5'b00100,
    B_CHK  = 5'b01000,
    B_DONE = 5'b10000
  } bstate_t;

  bstate_t       state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          mode_r, mode_nxt, res_r, res_nxt;
  logic [AW:0]   m_r, m_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt, i_r, i_nxt;
  logic [AW-1:0] pos_r, pos_nxt, b_r, b_nxt, c_r, c_nxt;
  logic [63:0]   s_r, s_nxt, h2_r, h2_nxt;
  logic          ov_r, ov_nxt, omp_r, omp_nxt;

  logic          e_mode;
  logic [AW:0]   e_m;
  logic [KW-1:0] e_cnt;
  logic [AW-1:0] e_a, e_b, e_c;
  logic [63:0]   e_h1, e_h2;

  logic [64:0]   ssum;
  logic [AW:0]   t1, t2;
  logic [AW-1:0] mem_addr;
  logic          mem_we, mem_wd, mem_q;
  logic          mem [MAX_FILTER_BITS];

  assign {e_mode, e_m, e_cnt, e_a, e_b, e_c, e_h1, e_h2} = pop_data;

  assign clearing          = (state_r == B_CLR);
  assign out_valid         = ov_r;
  assign out_maybe_present = omp_r;
  assign pop               = (state_r == B_IDLE) && !qstat.empty;

  // Next index: add h2 mod m, and take 2^64 mod m back out when the 64-bit sum wraps.
  always_comb begin
    ssum = {1'b0, s_r} + {1'b0, h2_r};
    t1   = {1'b0, pos_r} + {1'b0, b_r};
    if (t1 >= m_r) t1 = t1 - m_r;
    t2 = t1;
    if (ssum[64]) begin
      if (t1 >= {1'b0, c_r}) t2 = t1 - {1'b0, c_r};
      else t2 = t1 + m_r - {1'b0, c_r};
    end
  end

  always_comb begin
    mem_addr = clearing ? clr_r : pos_r;
    mem_we   = clearing || ((state_r == B_ACC) && (i_r != cnt_r) && (mode_r == MODE_INSERT));
    mem_wd   = !clearing;
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r; mode_nxt = mode_r; res_nxt = res_r; m_nxt = m_r;
    cnt_nxt = cnt_r; i_nxt = i_r; pos_nxt = pos_r; b_nxt = b_r; c_nxt = c_r;
    s_nxt = s_r; h2_nxt = h2_r;
    ov_nxt = ov_r && out_stall;
    omp_nxt = omp_r;
    case (state_r)
      B_CLR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_FILTER_BITS - 1)) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (!qstat.empty) begin
          mode_nxt = e_mode; m_nxt = e_m; cnt_nxt = e_cnt;
          pos_nxt = e_a; b_nxt = e_b; c_nxt = e_c;
          s_nxt = e_h1; h2_nxt = e_h2;
          i_nxt = '0;
          res_nxt = (e_mode == MODE_QUERY);
          state_nxt = B_ACC;
        end
      end
      B_ACC: begin
        if (i_r == cnt_r) begin
          state_nxt = B_DONE;
        end else if (mode_r == MODE_INSERT) begin
          i_nxt = i_r + KW'(1); s_nxt = ssum[63:0]; pos_nxt = t2[AW-1:0];
        end else begin
          state_nxt = B_CHK;
        end
      end
      B_CHK: begin
        if (!mem_q) begin
          res_nxt = 1'b0;
          state_nxt = B_DONE;
        end else begin
          i_nxt = i_r + KW'(1); s_nxt = ssum[63:0]; pos_nxt = t2[AW-1:0];
          state_nxt = B_ACC;
        end
      end
      B_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          omp_nxt = res_r;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt; res_r <= res_nxt; m_r <= m_nxt; cnt_r <= cnt_nxt;
    i_r <= i_nxt; pos_r <= pos_nxt; b_r <= b_nxt; c_r <= c_nxt;
    s_r <= s_nxt; h2_r <= h2_nxt; omp_r <= omp_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_q <= mem[mem_addr];
  end

endmodule

// ===== src/bloom_filter_insert_query_core.sv =====
// Flow: the front forms eighteen partial products on one shared 32x32 multiplier, works out
// the remainders two bits a cycle, then hands the indexes over into the queue; the back then
// sets (insert) or checks (query) up to k bit positions, k being the number of hash indexes.
// The front takes no new key until it has handed the last one over; the two-entry queue lets it
// run ahead of the back's walk, and result stalls hold back both. Reset: synchronous, active low;
// then a clearing pass zeroes every bit of the store while input is stalled.
module bloom_filter_insert_query_core #(
  parameter int unsigned MAX_FILTER_BITS = bfiq_pkg::MAX_FILTER_BITS_DEF,
  parameter int unsigned MAX_HASHES      = bfiq_pkg::MAX_HASHES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_mode,
  input  logic [bfiq_pkg::KEY_W-1:0] in_key,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_maybe_present,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bfiq_pkg::FB_W-1:0]  cfg_data
);
  import bfiq_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FILTER_BITS);
  localparam int unsigned KW = $clog2(MAX_HASHES + 1);
  localparam int unsigned EW = 1 + (AW + 1) + KW + 3 * AW + 128;

  logic [NH_W-1:0] hash_count_r;
  logic [FB_W-1:0] filter_bits_r;
  logic            fbusy, clearing, start, push, pop;
  logic [EW-1:0]   push_data, pop_data;
  bfiq_qstat_t     qstat;

  assign in_stall = fbusy || clearing;
  assign start    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_count_r  <= HASH_CNT_RST;
      filter_bits_r <= FILTER_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HASH_CNT:    hash_count_r  <= cfg_data[NH_W-1:0];
        REG_FILTER_BITS: filter_bits_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bfiq_front #(.MAX_FILTER_BITS(MAX_FILTER_BITS), .MAX_HASHES(MAX_HASHES), .EW(EW)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .mode(in_mode), .key(in_key),
    .hash_count(hash_count_r), .filter_bits(filter_bits_r), .busy(fbusy),
    .qstat(qstat), .push(push), .push_data(push_data)
  );

  bfiq_queue #(.EW(EW)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .qstat(qstat)
  );

  bfiq_back #(.MAX_FILTER_BITS(MAX_FILTER_BITS), .MAX_HASHES(MAX_HASHES), .EW(EW)) u_back (
    .clk(clk), .rst_n(rst_n), .qstat(qstat), .pop_data(pop_data), .pop(pop),
    .clearing(clearing), .out_valid(out_valid), .out_stall(out_stall),
    .out_maybe_present(out_maybe_present)
  );

`ifndef SYNTHESIS
  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid) else $error("result presented during store clearing");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full) else $error("queue written while full");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty) else $error("queue read while empty");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_maybe_present)))
    else $error("stalled result changed");
`endif

endmodule

// ===== tb/sv/tb_bloom_filter_insert_query_core.sv =====
module tb_bloom_filter_insert_query_core;
  import bfiq_pkg::*;

  localparam int unsigned STORE_BITS = MAX_FILTER_BITS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 8000000;

  typedef struct {
    logic             mode;
    logic [KEY_W-1:0] key;
  } key_op_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_mode = MODE_INSERT;
  logic [KEY_W-1:0]  in_key = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_maybe_present;
  logic              cfg_we = 1'b0;
  logic              cfg_index = REG_HASH_CNT;
  logic [FB_W-1:0]   cfg_data = '0;

  // Shadow of the filter and its registers.
  bit                shadow_store [0:STORE_BITS-1];
  logic [NH_W-1:0]   shadow_hashes = HASH_CNT_RST;
  logic [FB_W-1:0]   shadow_bits = FILTER_BITS_RST;

  key_op_t           pending_ops[$];
  logic              present_q[$];
  logic [KEY_W-1:0]  inserted_keys[$];
  int unsigned       errors = 0;
  int unsigned       send_gap = 0;
  int unsigned       stall_left = 0;
  int unsigned       quiet_cycles = 0;
  bit                idling_on = 1'b1;

  bloom_filter_insert_query_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode), .in_key(in_key),
    .out_valid(out_valid), .out_stall(out_stall), .out_maybe_present(out_maybe_present),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] fmix64(input logic [63:0] k);
    logic [63:0] m;
    m = k ^ (k >> 33);
    m = m * FMIX1;
    m = m ^ (m >> 33);
    m = m * FMIX2;
    return m ^ (m >> 33);
  endfunction

  // Applies one transaction to the shadow filter and returns the expected answer.
  function automatic logic lookup_or_insert(input logic mode, input logic [KEY_W-1:0] key);
    logic [63:0] k1, h1, h2, modulus, count, pos;
    logic        hit;
    k1 = {32'd0, key} * MM_C1;
    k1 = {k1[32:0], k1[63:33]};
    k1 = k1 * MM_C2;
    h1 = k1 ^ 64'd4;
    h2 = 64'd4;
    h1 = h1 + h2;
    h2 = h2 + h1;
    h1 = fmix64(h1);
    h2 = fmix64(h2);
    h1 = h1 + h2;
    h2 = h2 + h1;
    modulus = {42'd0, shadow_bits};
    if (modulus == 0) modulus = 64'd1;
    if (modulus > STORE_BITS) modulus = STORE_BITS;
    count = {58'd0, shadow_hashes};
    if (count > MAX_HASHES_DEF) count = MAX_HASHES_DEF;
    hit = (mode == MODE_QUERY);
    for (logic [63:0] i = 0; i < count; i++) begin
      pos = (h1 + i * h2) % modulus;
      if (mode == MODE_INSERT) begin
        shadow_store[pos] = 1'b1;
      end else if (!shadow_store[pos]) begin
        hit = 1'b0;
        break;
      end
    end
    return hit;
  endfunction

  // Driver.
  always @(posedge clk) begin
    key_op_t op;
    bit      busy;
    if (rst_n) begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        present_q.push_back(lookup_or_insert(in_mode, in_key));
        busy = 1'b0;
        if (idling_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 11);
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops.pop_front();
          in_valid <= 1'b1;
          in_mode <= op.mode;
          in_key <= op.key;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor, receiver stalls and watchdog.
  always @(posedge clk) begin
    logic want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (present_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual maybe_present=%0b",
                   $time, out_maybe_present);
          errors++;
        end else begin
          want = present_q.pop_front();
          if (out_maybe_present !== want) begin
            $display("%0t: maybe_present expected %0b actual %0b",
                     $time, want, out_maybe_present);
            errors++;
          end
        end
      end
      if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 11);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bloom_filter_insert_query_core: mismatch");
      $finish;
    end
  end

  task automatic add_op(input logic mode, input logic [KEY_W-1:0] key);
    key_op_t op;
    op.mode = mode;
    op.key = key;
    pending_ops.push_back(op);
    if (mode == MODE_INSERT) inserted_keys.push_back(key);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_ops.size() > 0 || in_valid || present_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [FB_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_HASH_CNT) shadow_hashes = value[NH_W-1:0];
    else shadow_bits = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_ops(input int n);
    int unsigned pick;
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 || inserted_keys.size() == 0)
        add_op(MODE_INSERT, $urandom);
      else if (pick < 85)
        add_op(MODE_QUERY, inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
      else
        add_op(MODE_QUERY, $urandom);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed transactions under the reset settings.
    add_op(MODE_QUERY, 32'h0000_0000);
    add_op(MODE_INSERT, 32'h0000_0000);
    add_op(MODE_QUERY, 32'h0000_0000);
    add_op(MODE_QUERY, 32'hFFFF_FFFF);
    add_op(MODE_INSERT, 32'hFFFF_FFFF);
    add_op(MODE_QUERY, 32'hFFFF_FFFF);
    add_op(MODE_INSERT, 32'h8000_0001);
    add_op(MODE_QUERY, 32'h8000_0001);
    add_op(MODE_QUERY, 32'h7FFF_FFFE);
    add_op(MODE_INSERT, 32'hA5A5_5A5A);
    add_op(MODE_QUERY, 32'h5A5A_A5A5);
    add_op(MODE_QUERY, 32'hA5A5_5A5A);
    wait_drained();

    // Zero hashes answer present; an oversized modulus is clamped.
    write_reg(REG_HASH_CNT, 22'h3FFFC0);
    write_reg(REG_FILTER_BITS, 22'h3FFFFF);
    add_op(MODE_QUERY, 32'h1234_5678);
    add_op(MODE_INSERT, 32'h1234_5678);
    add_op(MODE_QUERY, 32'hDEAD_BEEF);
    random_ops(20);
    wait_drained();

    // Too many hashes with a zero modulus: every index lands on bit zero.
    write_reg(REG_HASH_CNT, 22'd63);
    write_reg(REG_FILTER_BITS, 22'd0);
    add_op(MODE_QUERY, 32'h0F0F_0F0F);
    add_op(MODE_INSERT, 32'h0F0F_0F0F);
    add_op(MODE_QUERY, 32'hF0F0_F0F0);
    random_ops(20);
    wait_drained();

    write_reg(REG_HASH_CNT, 22'd32);
    write_reg(REG_FILTER_BITS, 22'd1);
    random_ops(30);
    wait_drained();

    write_reg(REG_HASH_CNT, 22'd1);
    write_reg(REG_FILTER_BITS, STORE_BITS[FB_W-1:0]);
    random_ops(70);
    wait_drained();

    // A small filter fills quickly, so false positives turn up.
    write_reg(REG_HASH_CNT, 22'd3);
    write_reg(REG_FILTER_BITS, 22'd1000);
    random_ops(60);
    wait_drained();
    random_ops(60);
    wait_drained();

    write_reg(REG_HASH_CNT, 22'd4);
    write_reg(REG_FILTER_BITS, 22'd64);
    random_ops(80);
    wait_drained();

    idling_on = 1'b0;
    write_reg(REG_HASH_CNT, 22'd7);
    write_reg(REG_FILTER_BITS, 22'd5000);
    random_ops(90);
    wait_drained();
    repeat (200) @(posedge clk);

    if (present_q.size() != 0) begin
      $display("%0t: %0d results expected but never seen", $time, present_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("bloom_filter_insert_query_core: match");
    end else begin
      $display("bloom_filter_insert_query_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/bfiq_pkg.sv
src/bfiq_front.sv
src/bfiq_queue.sv
src/bfiq_back.sv
src/bloom_filter_insert_query_core.sv
tb/sv/tb_bloom_filter_insert_query_core.sv
